@@ sv/pvi_pkg.sv @@
// Shared types, constants and saturating helpers for the particle integrator.
package pvi_pkg;

  localparam int WordBits  = 32;
  localparam int FracBits  = 16;
  localparam int DtBits    = 24;
  localparam int DragBits  = 16;
  localparam int ExtBits   = 31;
  localparam int MassBits  = WordBits + 4;
  localparam int DvdBits   = WordBits + FracBits;
  localparam int CntBits   = $clog2(DvdBits);
  localparam int ProdBits  = 2 * WordBits;

  // Minimum raw mass: round(0.1 * 2^FracBits)
  localparam logic [WordBits-1:0] MassFloor = WordBits'(((1 << FracBits) + 5) / 10);
  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  // Action codes
  localparam logic [2:0] ActSetPos   = 3'd0;
  localparam logic [2:0] ActSetVel   = 3'd1;
  localparam logic [2:0] ActSetAcc   = 3'd2;
  localparam logic [2:0] ActClrPend  = 3'd3;
  localparam logic [2:0] ActAddForce = 3'd4;
  localparam logic [2:0] ActUpdVel   = 3'd5;
  localparam logic [2:0] ActMove     = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] RegMass  = 2'd0;
  localparam logic [1:0] RegDrag  = 2'd1;
  localparam logic [1:0] RegExtX  = 2'd2;
  localparam logic [1:0] RegExtY  = 2'd3;

  typedef struct packed {
    logic [2:0]                 action;
    logic signed [WordBits-1:0] x_value;
    logic signed [WordBits-1:0] y_value;
    logic [DtBits-1:0]          time_step;
  } req_t;

  typedef struct packed {
    logic signed [WordBits-1:0] pos_x;
    logic signed [WordBits-1:0] pos_y;
    logic signed [WordBits-1:0] vel_x;
    logic signed [WordBits-1:0] vel_y;
  } res_t;

  typedef struct packed {
    logic [WordBits-1:0] mass_setting;
    logic [DragBits-1:0] drag_rate;
    logic [ExtBits-1:0]  half_extent_x;
    logic [ExtBits-1:0]  half_extent_y;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_SET_POS, OP_SET_VEL, OP_SET_ACC, OP_CLR_PEND,
    OP_F_START, OP_DIV_STEP, OP_F_DONE,
    OP_V_SUM, OP_V_MUL1, OP_V_ADD1, OP_V_MUL2, OP_V_SUB, OP_V_COPY,
    OP_M_MUL1, OP_M_ADD1, OP_M_MUL2, OP_M_ADD2, OP_W_START, OP_W_DONE
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

  // Signed word from a magnitude and a sign, saturated
  function automatic logic signed [WordBits-1:0] sat_mag(input logic [ProdBits-1:0] m,
                                                         input logic neg);
    logic [ProdBits-1:0] lim;
    lim = ProdBits'(WordMax);
    if (neg) begin
      if (m > lim) return WordMin;
      return -$signed(m[WordBits-1:0]);
    end
    if (m > lim) return WordMax;
    return $signed(m[WordBits-1:0]);
  endfunction

  function automatic logic signed [WordBits-1:0] clamp_wide(input logic signed [WordBits:0] s);
    if (s > $signed({WordMax[WordBits-1], WordMax})) return WordMax;
    if (s < $signed({WordMin[WordBits-1], WordMin})) return WordMin;
    return s[WordBits-1:0];
  endfunction

  function automatic logic signed [WordBits-1:0] add_sat(input logic signed [WordBits-1:0] a,
                                                         input logic signed [WordBits-1:0] b);
    return clamp_wide($signed({a[WordBits-1], a}) + $signed({b[WordBits-1], b}));
  endfunction

  function automatic logic signed [WordBits-1:0] sub_sat(input logic signed [WordBits-1:0] a,
                                                         input logic signed [WordBits-1:0] b);
    return clamp_wide($signed({a[WordBits-1], a}) - $signed({b[WordBits-1], b}));
  endfunction

  function automatic logic [WordBits-1:0] mag(input logic signed [WordBits-1:0] a);
    return a[WordBits-1] ? WordBits'(-a) : WordBits'(a);
  endfunction

endpackage

@@ sv/pvi_ctrl.sv @@
// Sequencer for the particle integrator: steps each action through the datapath.
module pvi_ctrl import pvi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] action_i,
  input  stat_t      stat_i,
  output logic       busy_o,
  output logic       done_o,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SIMPLE, S_F_START, S_DIV, S_F_DONE,
    S_V_SUM, S_V_MUL1, S_V_ADD1, S_V_MUL2, S_V_SUB, S_V_COPY,
    S_M_MUL1, S_M_ADD1, S_M_MUL2, S_M_ADD2, S_W_START, S_W_DONE, S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic       axis_q, axis_d;
  logic [2:0] act_q, act_d;
  logic       done_q, done_d;

  // Next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    act_d   = act_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d  = action_i;
          axis_d = 1'b0;
          case (action_i)
            ActAddForce: state_d = S_F_START;
            ActUpdVel:   state_d = S_V_SUM;
            ActMove:     state_d = S_M_MUL1;
            default:     state_d = S_SIMPLE;
          endcase
        end
      end
      S_SIMPLE:  state_d = S_DONE;
      S_F_START: state_d = S_DIV;
      S_DIV: begin
        if (stat_i.div_last) state_d = (act_q == ActAddForce) ? S_F_DONE : S_W_DONE;
      end
      S_F_DONE: begin
        axis_d  = 1'b1;
        state_d = axis_q ? S_DONE : S_F_START;
      end
      S_V_SUM:  state_d = S_V_MUL1;
      S_V_MUL1: state_d = S_V_ADD1;
      S_V_ADD1: state_d = S_V_MUL2;
      S_V_MUL2: state_d = S_V_SUB;
      S_V_SUB:  state_d = S_V_COPY;
      S_V_COPY: begin
        axis_d  = 1'b1;
        state_d = axis_q ? S_DONE : S_V_SUM;
      end
      S_M_MUL1:  state_d = S_M_ADD1;
      S_M_ADD1:  state_d = S_M_MUL2;
      S_M_MUL2:  state_d = S_M_ADD2;
      S_M_ADD2:  state_d = S_W_START;
      S_W_START: state_d = S_DIV;
      S_W_DONE: begin
        axis_d  = 1'b1;
        state_d = axis_q ? S_DONE : S_M_MUL1;
      end
      S_DONE: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
      act_q   <= ActSetPos;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      act_q   <= act_d;
      done_q  <= done_d;
    end
  end

  // Decode the datapath command
  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && start_i;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_SIMPLE: begin
        case (act_q)
          ActSetPos:  cmd_o.op = OP_SET_POS;
          ActSetVel:  cmd_o.op = OP_SET_VEL;
          ActSetAcc:  cmd_o.op = OP_SET_ACC;
          ActClrPend: cmd_o.op = OP_CLR_PEND;
          default:    cmd_o.op = OP_NONE;
        endcase
      end
      S_F_START: cmd_o.op = OP_F_START;
      S_DIV:     cmd_o.op = OP_DIV_STEP;
      S_F_DONE:  cmd_o.op = OP_F_DONE;
      S_V_SUM:   cmd_o.op = OP_V_SUM;
      S_V_MUL1:  cmd_o.op = OP_V_MUL1;
      S_V_ADD1:  cmd_o.op = OP_V_ADD1;
      S_V_MUL2:  cmd_o.op = OP_V_MUL2;
      S_V_SUB:   cmd_o.op = OP_V_SUB;
      S_V_COPY:  cmd_o.op = OP_V_COPY;
      S_M_MUL1:  cmd_o.op = OP_M_MUL1;
      S_M_ADD1:  cmd_o.op = OP_M_ADD1;
      S_M_MUL2:  cmd_o.op = OP_M_MUL2;
      S_M_ADD2:  cmd_o.op = OP_M_ADD2;
      S_W_START: cmd_o.op = OP_W_START;
      S_W_DONE:  cmd_o.op = OP_W_DONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ sv/pvi_datapath.sv @@
// Particle state, shared multiplier and shared restoring divider.
module pvi_datapath import pvi_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cfg_t  cfg_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output res_t  res_o
);

  req_t                       req_q;
  logic signed [WordBits-1:0] pos_q [2];
  logic signed [WordBits-1:0] vel_q [2];
  logic signed [WordBits-1:0] acc_q [2];
  logic signed [WordBits-1:0] pend_q [2];
  logic signed [WordBits-1:0] t_q;
  logic [DtBits-1:0]          dd_q;
  logic [WordBits-1:0]        d2_q;
  logic [ProdBits-1:0]        prod_q;
  logic                       neg_q;
  logic [DvdBits-1:0]         dvd_q;
  logic [MassBits-1:0]        rem_q;
  logic [MassBits-1:0]        dvs_q;
  logic [CntBits-1:0]         cnt_q;

  logic                       ax;
  logic signed [WordBits-1:0] in_v;
  logic [ExtBits-1:0]         ext;
  logic [WordBits-1:0]        wid;
  logic [WordBits-1:0]        mass_base;
  logic [MassBits-1:0]        mass;
  logic [WordBits-1:0]        mul_a, mul_b;
  logic [ProdBits-1:0]        mul_p;
  logic [MassBits:0]          rem_sh;
  logic                       ge;
  logic signed [WordBits-1:0] prod_f, prod_f1, quot_v;
  logic [WordBits-1:0]        rr, ru;
  logic [WordBits:0]          r2, r3;
  logic signed [WordBits-1:0] wrapped;
  logic [DragBits+DtBits-1:0] dd_full;
  logic [2*DtBits-1:0]        d2_full;

  assign ax   = cmd_i.axis;
  assign in_v = ax ? req_q.y_value : req_q.x_value;
  assign ext  = ax ? cfg_i.half_extent_y : cfg_i.half_extent_x;
  assign wid  = {ext, 1'b0};

  // Effective mass: max(raw, floor) * 10
  assign mass_base = (cfg_i.mass_setting < MassFloor) ? MassFloor : cfg_i.mass_setting;
  assign mass = {1'b0, mass_base, 3'b0} + {3'b0, mass_base, 1'b0};

  // Shared multiplier operand select
  always_comb begin
    mul_a = mag(vel_q[ax]);
    mul_b = WordBits'(req_q.time_step);
    case (cmd_i.op)
      OP_V_MUL1: mul_a = mag(t_q);
      OP_V_MUL2: mul_b = WordBits'(dd_q);
      OP_M_MUL2: begin
        mul_a = mag(acc_q[ax]);
        mul_b = d2_q;
      end
      default: ;
    endcase
  end
  assign mul_p = ProdBits'(mul_a) * ProdBits'(mul_b);

  assign dd_full = DragBits'(cfg_i.drag_rate) * DtBits'(req_q.time_step);
  assign d2_full = (2*DtBits)'(req_q.time_step) * (2*DtBits)'(req_q.time_step);

  // Scaled products and divider step
  assign prod_f  = sat_mag(prod_q >> FracBits, neg_q);
  assign prod_f1 = sat_mag(prod_q >> (FracBits + 1), neg_q);
  assign quot_v  = sat_mag(ProdBits'(dvd_q), neg_q);
  assign rem_sh  = {rem_q, dvd_q[DvdBits-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});

  // Toroidal wrap from the remainder
  always_comb begin
    ru = rem_q[WordBits-1:0];
    rr = (neg_q && (ru != '0)) ? wid - ru : ru;
    r2 = {1'b0, rr} + {2'b0, ext};
    r3 = (r2 >= {1'b0, wid}) ? r2 - {1'b0, wid} : r2;
    wrapped = (ext == '0) ? '0 : WordBits'(r3 - {2'b0, ext});
  end

  assign stat_o.div_last = (cnt_q == '0);

  // Execute one command per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        pos_q[i]  <= '0;
        vel_q[i]  <= '0;
        acc_q[i]  <= '0;
        pend_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_SET_POS: begin
          pos_q[0] <= req_q.x_value;
          pos_q[1] <= req_q.y_value;
        end
        OP_SET_VEL: begin
          vel_q[0] <= req_q.x_value;
          vel_q[1] <= req_q.y_value;
        end
        OP_SET_ACC: begin
          acc_q[0]  <= req_q.x_value;
          acc_q[1]  <= req_q.y_value;
          pend_q[0] <= req_q.x_value;
          pend_q[1] <= req_q.y_value;
        end
        OP_CLR_PEND: begin
          pend_q[0] <= '0;
          pend_q[1] <= '0;
        end
        OP_F_START:  cnt_q <= CntBits'(DvdBits - 1);
        OP_W_START:  cnt_q <= CntBits'(DvdBits - 1);
        OP_DIV_STEP: cnt_q <= cnt_q - 1'b1;
        OP_F_DONE:   pend_q[ax] <= add_sat(pend_q[ax], quot_v);
        OP_V_ADD1:   vel_q[ax] <= add_sat(vel_q[ax], prod_f1);
        OP_V_SUB:    vel_q[ax] <= sub_sat(vel_q[ax], prod_f);
        OP_V_COPY:   acc_q[ax] <= pend_q[ax];
        OP_W_DONE:   pos_q[ax] <= wrapped;
        default: ;
      endcase
    end
  end

  // Payload registers: request, temporaries, divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    case (cmd_i.op)
      OP_F_START: begin
        neg_q <= in_v[WordBits-1];
        dvd_q <= {mag(in_v), FracBits'(0)};
        dvs_q <= mass;
        rem_q <= '0;
      end
      OP_W_START: begin
        neg_q <= t_q[WordBits-1];
        dvd_q <= {FracBits'(0), mag(t_q)};
        dvs_q <= MassBits'(wid);
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        dvd_q <= {dvd_q[DvdBits-2:0], ge};
        rem_q <= ge ? MassBits'(rem_sh - {1'b0, dvs_q}) : MassBits'(rem_sh);
      end
      OP_V_SUM: begin
        t_q  <= add_sat(acc_q[ax], pend_q[ax]);
        dd_q <= DtBits'(dd_full >> FracBits);
      end
      OP_V_MUL1: begin
        prod_q <= mul_p;
        neg_q  <= t_q[WordBits-1];
      end
      OP_V_MUL2: begin
        prod_q <= mul_p;
        neg_q  <= vel_q[ax][WordBits-1];
      end
      OP_M_MUL1: begin
        prod_q <= mul_p;
        neg_q  <= vel_q[ax][WordBits-1];
        d2_q   <= WordBits'(d2_full >> FracBits);
      end
      OP_M_ADD1: t_q <= add_sat(pos_q[ax], prod_f);
      OP_M_MUL2: begin
        prod_q <= mul_p;
        neg_q  <= acc_q[ax][WordBits-1];
      end
      OP_M_ADD2: t_q <= add_sat(t_q, prod_f1);
      default: ;
    endcase
  end

  assign res_o.pos_x = pos_q[0];
  assign res_o.pos_y = pos_q[1];
  assign res_o.vel_x = vel_q[0];
  assign res_o.vel_y = vel_q[1];

endmodule

@@ sv/particle_verlet_integrator_unit.sv @@
// Top level of the particle integrator: configuration registers, sequencer and datapath.
//
//   channel  | handshake                  | payload
//   request  | start_i / busy_o           | req_i (req_t)
//   result   | done_o (one-cycle strobe)  | res_o (res_t)
//   config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Add force and move use the shared restoring divider, which retires one quotient
// bit per cycle over 48 bits, once per axis. busy_o drops in the done_o cycle,
// so the next request can be taken at the edge that ends the result strobe.
// Reset clears the particle state and loads the register defaults.
// Results cannot be stalled; configuration writes are always accepted.
module particle_verlet_integrator_unit import pvi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  req_t        req_i,
  output logic        busy_o,
  output logic        done_o,
  output res_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mass_setting  <= 32'd65536;
      cfg_q.drag_rate     <= '0;
      cfg_q.half_extent_x <= 31'd65536000;
      cfg_q.half_extent_y <= 31'd65536000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMass: cfg_q.mass_setting  <= cfg_data_i;
        RegDrag: cfg_q.drag_rate     <= cfg_data_i[DragBits-1:0];
        RegExtX: cfg_q.half_extent_x <= cfg_data_i[ExtBits-1:0];
        RegExtY: cfg_q.half_extent_y <= cfg_data_i[ExtBits-1:0];
        default: ;
      endcase
    end
  end

  pvi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .action_i (req_i.action),
    .stat_i   (stat),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  pvi_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule
